// ===== design/qwu_pkg.sv =====
package qwu_pkg;

   // Fixed-point one (Q16.16) and the default fan-in limit.
   localparam int Q_ONE       = 65536;
   localparam int MAX_FAN_IN_DEF = 64;

   // Numerator width used by both pipelined dividers.
   localparam int DIV_NW = 63;

   typedef enum logic [2:0] {
      CSR_EPSILON   = 3'd0,
      CSR_MOMENTUM  = 3'd1,
      CSR_THRESHOLD = 3'd2,
      CSR_MAX_FACTOR = 3'd3,
      CSR_SPLIT_GAIN = 3'd4
   } csr_index_type;

   // Side information that travels through the quadratic divider.
   typedef struct packed {
      logic               jump;
      logic               take_max;
      logic               grad;
      logic               eps_add;
      logic               zero_den;
      logic               s_zero;
      logic               zsign;
      logic               quad_neg;
      logic signed [47:0] lin;
      logic signed [31:0] weight;
   } tag_type;

endpackage

// ===== design/qwu_div.sv =====
module qwu_div #(
   parameter int NW = 63,
   parameter int DW = 32,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [TW-1:0] tag,
   output logic          out_valid,
   output logic [NW-1:0] quo,
   output logic [TW-1:0] tag_out
);
   // Restoring division, one quotient bit per pipeline stage.
   logic          v_ff   [NW];
   logic [NW-1:0] nq_ff  [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [TW-1:0] tag_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          v_src;
      logic [NW-1:0] nq_src;
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [TW-1:0] tag_src;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign nq_src  = num;
         assign rem_src = '0;
         assign den_src = den;
         assign tag_src = tag;
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign nq_src  = nq_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      always_comb begin
         trial  = {rem_src, nq_src[NW-1]};
         ge     = trial >= {1'b0, den_src};
         rem_in = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
         nq_in  = {nq_src[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k]  <= nq_in;
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            tag_ff[k] <= tag_src;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign quo       = nq_ff[NW-1];
   assign tag_out   = tag_ff[NW-1];

endmodule

// ===== design/quickprop_weight_update_unit.sv =====
// Quickprop weight update, one weight per transaction. Each request carries
// a weight, its last step, its current and previous slope and the fan-in of
// its unit (all Q16.16 signed except fan-in); the response carries the new
// step, the new weight and two flags. While the response is not stalled
// the pipeline accepts one transaction every clock cycle and returns
// results in order. Its stages are an input register, a multiply stage, a
// preparation stage, 63 stages of the bit-per-stage divider that forms the
// quadratic estimate (the epsilon term divided by fan-in runs in a twin
// divider alongside), a combine stage and the output register. When the
// response is stalled the whole pipeline holds and req_tready is low;
// nothing is lost or repeated. Configuration writes on the csr_ port take
// effect at once and are meant to be made while the pipeline is empty.
module quickprop_weight_update_unit #(
   parameter int MAX_FAN_IN = qwu_pkg::MAX_FAN_IN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // Request: slope [31:0], prev_slope [63:32], last_step [95:64],
   // weight_in [127:96], fan_in [134:128], zero [135].
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,
   // Response: step_out [31:0], weight_out [63:32].
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,
   // Response flags: used_gradient [0], saturated [1].
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata
);
   import qwu_pkg::*;

   localparam int FW = $clog2(MAX_FAN_IN + 1);
   localparam int TW = $bits(tag_type);
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // Divide a signed product by 65536, rounding to nearest, ties away from zero.
   function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] x);
      logic [63:0] mag;
      logic [47:0] q;
      begin
         mag = x[63] ? 64'(-x) : 64'(x);
         q   = 48'((mag + 64'd32768) >> 16);
         return x[63] ? $signed(-q) : $signed(q);
      end
   endfunction

   // Configuration registers.
   logic [19:0] epsilon_ff;
   logic [16:0] momentum_ff;
   logic [19:0] threshold_ff;
   logic [19:0] max_factor_ff;
   logic        split_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff    <= 20'd36045;
         momentum_ff   <= 17'd58982;
         threshold_ff  <= 20'd0;
         max_factor_ff <= 20'd114688;
         split_gain_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_EPSILON:    epsilon_ff    <= csr_wdata;
            CSR_MOMENTUM:   momentum_ff   <= csr_wdata[16:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata;
            CSR_MAX_FACTOR: max_factor_ff <= csr_wdata;
            CSR_SPLIT_GAIN: split_gain_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together whenever the output register can
   // take a new value.
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Stage A: input register.
   logic               a_valid_ff;
   logic signed [31:0] a_s_ff, a_p_ff, a_d_ff, a_w_ff;
   logic [6:0]         a_fan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_s_ff   <= req_tdata[31:0];
         a_p_ff   <= req_tdata[63:32];
         a_d_ff   <= req_tdata[95:64];
         a_w_ff   <= req_tdata[127:96];
         a_fan_ff <= req_tdata[134:128];
      end
   end

   // Stage B: products, the mode decision and the quadratic divisor.
   logic               b_valid_ff;
   logic signed [52:0] b_eps_prod_ff, b_eps_prod_in;
   logic signed [63:0] b_sd_ff, b_sd_in;
   logic signed [52:0] b_mfd_ff, b_mfd_in;
   logic signed [49:0] b_momd_ff, b_momd_in;
   logic signed [53:0] b_lhs_ff, b_lhs_in;
   logic signed [52:0] b_rhs_ff, b_rhs_in;
   logic signed [32:0] b_den_ff, b_den_in;
   logic               b_pos_ff, b_pos_in;
   logic               b_negdir_ff, b_negdir_in;
   logic [FW-1:0]      b_fan_ff, b_fan_in;
   logic signed [31:0] b_s_ff, b_d_ff, b_w_ff;

   always_comb begin
      logic signed [32:0] thr;
      logic [20:0]        mf_one;
      thr    = $signed({13'b0, threshold_ff});
      mf_one = 21'(Q_ONE) + {1'b0, max_factor_ff};
      if (!split_gain_ff || a_fan_ff == 7'd0) begin
         b_fan_in = FW'(1);
      end else if (32'(a_fan_ff) > MAX_FAN_IN) begin
         b_fan_in = FW'(MAX_FAN_IN);
      end else begin
         b_fan_in = FW'(a_fan_ff);
      end
      b_eps_prod_in = $signed({1'b0, epsilon_ff}) * a_s_ff;
      b_sd_in       = a_s_ff * a_d_ff;
      b_mfd_in      = $signed({1'b0, max_factor_ff}) * a_d_ff;
      b_momd_in     = $signed({1'b0, momentum_ff}) * a_d_ff;
      b_lhs_in      = a_s_ff * $signed({1'b0, mf_one});
      b_rhs_in      = $signed({1'b0, max_factor_ff}) * a_p_ff;
      b_den_in      = 33'(a_p_ff) - 33'(a_s_ff);
      b_pos_in      = 33'(a_d_ff) > thr;
      b_negdir_in   = 33'(a_d_ff) < -thr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_eps_prod_ff <= b_eps_prod_in;
         b_sd_ff       <= b_sd_in;
         b_mfd_ff      <= b_mfd_in;
         b_momd_ff     <= b_momd_in;
         b_lhs_ff      <= b_lhs_in;
         b_rhs_ff      <= b_rhs_in;
         b_den_ff      <= b_den_in;
         b_pos_ff      <= b_pos_in;
         b_negdir_ff   <= b_negdir_in;
         b_fan_ff      <= b_fan_in;
         b_s_ff        <= a_s_ff;
         b_d_ff        <= a_d_ff;
         b_w_ff        <= a_w_ff;
      end
   end

   // Stage C: rounded numerators, divisor magnitudes and branch flags.
   logic               c_valid_ff;
   logic [62:0]        c_eps_num_ff, c_eps_num_in;
   logic [FW-1:0]      c_fan_ff;
   logic               c_eps_neg_ff;
   logic [62:0]        c_quad_num_ff, c_quad_num_in;
   logic [31:0]        c_den_mag_ff, c_den_mag_in;
   tag_type            c_tag_ff, c_tag_in;

   always_comb begin
      logic [52:0] eps_mag;
      logic [63:0] eps_sum;
      logic [63:0] sd_mag;
      logic        jump;
      logic        take_max;
      logic signed [47:0] mf_term;
      logic signed [47:0] mom_term;
      eps_mag  = b_eps_prod_ff[52] ? 53'(-b_eps_prod_ff) : 53'(b_eps_prod_ff);
      // Round to nearest by adding half the divisor fan * 65536 before the
      // 16-bit shift; the remaining floor division by fan is exact.
      eps_sum  = 64'(eps_mag) + (64'(b_fan_ff) << 15);
      c_eps_num_in = 63'(eps_sum >> 16);
      sd_mag   = b_sd_ff[63] ? 64'(-b_sd_ff) : 64'(b_sd_ff);
      c_den_mag_in = b_den_ff[32] ? 32'(-b_den_ff) : 32'(b_den_ff);
      c_quad_num_in = 63'(sd_mag) + 63'(c_den_mag_in >> 1);
      jump     = b_pos_ff || b_negdir_ff;
      take_max = b_pos_ff ? (b_lhs_ff > b_rhs_ff) : (b_lhs_ff < b_rhs_ff);
      mf_term  = rnd_q16(64'(b_mfd_ff));
      mom_term = rnd_q16(64'(b_momd_ff));
      c_tag_in.jump     = jump;
      c_tag_in.take_max = take_max;
      c_tag_in.grad     = !jump;
      c_tag_in.eps_add  = !jump || (b_pos_ff && b_s_ff > 0)
                          || (!b_pos_ff && b_s_ff < 0);
      c_tag_in.zero_den = b_den_ff == 33'sd0;
      c_tag_in.s_zero   = b_s_ff == 32'sd0;
      c_tag_in.zsign    = (b_s_ff > 0) == (b_d_ff > 0);
      c_tag_in.quad_neg = b_sd_ff[63] ^ b_den_ff[32];
      c_tag_in.lin      = !jump ? mom_term : (take_max ? mf_term : 48'sd0);
      c_tag_in.weight   = b_w_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_eps_num_ff  <= c_eps_num_in;
         c_fan_ff      <= b_fan_ff;
         c_eps_neg_ff  <= b_eps_prod_ff[52];
         c_quad_num_ff <= c_quad_num_in;
         c_den_mag_ff  <= c_den_mag_in;
         c_tag_ff      <= c_tag_in;
      end
   end

   // Twin dividers of equal depth, so their outputs stay aligned.
   logic          eq_valid;
   logic [62:0]   eq_quo;
   logic [0:0]    eq_tag;
   logic          qq_valid;
   logic [62:0]   qq_quo;
   logic [TW-1:0] qq_tag;
   tag_type       d_tag;

   qwu_div #(.NW(DIV_NW), .DW(FW), .TW(1)) u_eps_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c_valid_ff),
      .num      (c_eps_num_ff),
      .den      (c_fan_ff),
      .tag      (c_eps_neg_ff),
      .out_valid(eq_valid),
      .quo      (eq_quo),
      .tag_out  (eq_tag)
   );

   qwu_div #(.NW(DIV_NW), .DW(32), .TW(TW)) u_quad_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c_valid_ff),
      .num      (c_quad_num_ff),
      .den      (c_den_mag_ff),
      .tag      (c_tag_ff),
      .out_valid(qq_valid),
      .quo      (qq_quo),
      .tag_out  (qq_tag)
   );

   assign d_tag = tag_type'(qq_tag);

   // Stage F: combine the terms and clamp the step.
   logic               f_valid_ff;
   logic signed [31:0] f_step_ff, f_step_in;
   logic signed [31:0] f_w_ff;
   logic               f_sat_ff, f_sat_in;
   logic               f_grad_ff;

   always_comb begin
      logic signed [47:0] eps_val;
      logic signed [31:0] quad_val;
      logic signed [47:0] next;
      logic               qsat;
      eps_val  = eq_tag[0] ? $signed(-48'(eq_quo)) : $signed(48'(eq_quo));
      qsat     = 1'b0;
      if (d_tag.zero_den) begin
         qsat     = 1'b1;
         quad_val = d_tag.s_zero ? 32'sd0 : (d_tag.zsign ? S32_MAX : S32_MIN);
      end else if (d_tag.quad_neg) begin
         if (qq_quo > 63'h8000_0000) begin
            qsat     = 1'b1;
            quad_val = S32_MIN;
         end else begin
            quad_val = 32'(-qq_quo);
         end
      end else begin
         if (qq_quo > 63'h7FFF_FFFF) begin
            qsat     = 1'b1;
            quad_val = S32_MAX;
         end else begin
            quad_val = 32'(qq_quo);
         end
      end
      // The quadratic estimate counts only in jump mode without the cap.
      if (!d_tag.jump || d_tag.take_max) begin
         qsat = 1'b0;
      end
      next = (d_tag.eps_add ? eps_val : 48'sd0) + d_tag.lin
             + ((d_tag.jump && !d_tag.take_max) ? 48'(quad_val) : 48'sd0);
      f_sat_in = qsat;
      if (next > 48'(S32_MAX)) begin
         f_step_in = S32_MAX;
         f_sat_in  = 1'b1;
      end else if (next < 48'(S32_MIN)) begin
         f_step_in = S32_MIN;
         f_sat_in  = 1'b1;
      end else begin
         f_step_in = 32'(next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= qq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_step_ff <= f_step_in;
         f_w_ff    <= d_tag.weight;
         f_sat_ff  <= f_sat_in;
         f_grad_ff <= d_tag.grad;
      end
   end

   // Output register: the weight sum and its clamp.
   logic signed [31:0] rsp_step_ff;
   logic signed [31:0] rsp_weight_ff, rsp_weight_in;
   logic               rsp_grad_ff;
   logic               rsp_sat_ff, rsp_sat_in;

   always_comb begin
      logic signed [32:0] wsum;
      wsum       = 33'(f_w_ff) + 33'(f_step_ff);
      rsp_sat_in = f_sat_ff;
      if (wsum > 33'(S32_MAX)) begin
         rsp_weight_in = S32_MAX;
         rsp_sat_in    = 1'b1;
      end else if (wsum < 33'(S32_MIN)) begin
         rsp_weight_in = S32_MIN;
         rsp_sat_in    = 1'b1;
      end else begin
         rsp_weight_in = 32'(wsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_step_ff   <= f_step_ff;
         rsp_weight_ff <= rsp_weight_in;
         rsp_grad_ff   <= f_grad_ff;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_weight_ff, rsp_step_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_grad_ff};

`ifndef SYNTHESIS
   // A stalled response must hold the whole pipeline.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request accepted while response stalled");

   // The two dividers must stay in lockstep.
   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      eq_valid == qq_valid)
      else $error("divider valid bits out of step");

   // A zero quadratic divisor that is used must end up flagged.
   a_zero_den_flag: assert property (@(posedge clock) disable iff (reset)
      (en && qq_valid && d_tag.jump && !d_tag.take_max && d_tag.zero_den)
      |=> f_sat_ff)
      else $error("zero divisor not flagged");
`endif

endmodule

// ===== bench/quickprop_weight_update_unit_tb.sv =====
`timescale 1ns / 1ps

module quickprop_weight_update_unit_tb;
   import qwu_pkg::*;

   // The quiet period before a register write and at the end is set
   // comfortably above the pipeline depth.
   localparam int PIPE_LATENCY = 68;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_RANDOM = 600;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] step;
      logic signed [31:0] weight;
      logic               grad;
      logic               sat;
   } update_type;

   typedef struct {
      logic signed [31:0] slope;
      logic signed [31:0] prev_slope;
      logic signed [31:0] last_step;
      logic signed [31:0] weight;
      logic [6:0]         fan_in;
      bit                 has_fixed;
      update_type         fixed;
   } weight_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [19:0]  csr_wdata;

   // Local copy of the configuration registers.
   logic [19:0] epsilon_q;
   logic [16:0] momentum_q;
   logic [19:0] threshold_q;
   logic [19:0] max_factor_q;
   logic        split_q;

   update_type     pending_updates[$];
   weight_row_type directed_rows[$];
   int  error_count;
   int  idle_cycles;
   int  send_idle_pct;
   int  recv_stall_pct;

   quickprop_weight_update_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Rounded division, ties away from zero; the divisor is positive.
   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp32(longint v, inout bit flag);
      if (v > S32_MAX) begin
         flag = 1'b1;
         return S32_MAX;
      end
      if (v < S32_MIN) begin
         flag = 1'b1;
         return S32_MIN;
      end
      return v;
   endfunction

   // Computes the quickprop update of one weight under the current registers.
   function automatic update_type quickprop_update(logic signed [31:0] s_in,
         logic signed [31:0] p_in, logic signed [31:0] d_in,
         logic signed [31:0] w_in, logic [6:0] fan_raw);
      update_type r;
      longint s, p, d, w, thr, mf, fan, eps_term, next, lhs, rhs, den, q;
      bit flag, pos, take_max;
      s = s_in;
      p = p_in;
      d = d_in;
      w = w_in;
      thr = threshold_q;
      mf = max_factor_q;
      flag = 1'b0;
      next = 0;
      fan = fan_raw;
      if (fan < 1) fan = 1;
      if (fan > 64) fan = 64;
      if (!split_q) fan = 1;
      eps_term = round_div(longint'(epsilon_q) * s, fan * Q_ONE);
      r.grad = 1'b0;
      if (d > thr || d < -thr) begin
         pos = d > thr;
         lhs = s * (Q_ONE + mf);
         rhs = mf * p;
         take_max = pos ? (lhs > rhs) : (lhs < rhs);
         if ((pos && s > 0) || (!pos && s < 0)) next += eps_term;
         if (take_max) begin
            next += round_div(mf * d, Q_ONE);
         end else begin
            den = p - s;
            if (den == 0) begin
               // A zero divisor saturates toward the sign of slope * step.
               flag = 1'b1;
               if (s == 0) q = 0;
               else q = ((s > 0) == (d > 0)) ? S32_MAX : S32_MIN;
            end else begin
               q = round_div(s * d, (den < 0) ? -den : den);
               if (den < 0) q = -q;
               q = clamp32(q, flag);
            end
            next += q;
         end
      end else begin
         r.grad = 1'b1;
         next = eps_term + round_div(longint'(momentum_q) * d, Q_ONE);
      end
      next = clamp32(next, flag);
      r.step = next[31:0];
      r.weight = 32'(clamp32(w + next, flag));
      r.sat = flag;
      return r;
   endfunction

   // Checks every response transaction against the oldest expected update.
   always @(posedge clock) begin
      update_type got;
      update_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.step = rsp_tdata[31:0];
         got.weight = rsp_tdata[63:32];
         got.grad = rsp_tuser[0];
         got.sat = rsp_tuser[1];
         if (pending_updates.size() == 0) begin
            $error("unexpected response: step_out %0d", got.step);
            error_count++;
         end else begin
            want = pending_updates.pop_front();
            if (got.step !== want.step) begin
               $error("step_out: expected %0d, actual %0d", want.step, got.step);
               error_count++;
            end
            if (got.weight !== want.weight) begin
               $error("weight_out: expected %0d, actual %0d", want.weight, got.weight);
               error_count++;
            end
            if (got.grad !== want.grad) begin
               $error("used_gradient: expected %0d, actual %0d", want.grad, got.grad);
               error_count++;
            end
            if (got.sat !== want.sat) begin
               $error("saturated: expected %0d, actual %0d", want.sat, got.sat);
               error_count++;
            end
         end
      end
   end

   // Receiver side: stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: counts cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Writes one register; only called while the pipeline is empty.
   task automatic write_reg(csr_index_type idx, logic [19:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_EPSILON: epsilon_q = value;
         CSR_MOMENTUM: momentum_q = value[16:0];
         CSR_THRESHOLD: threshold_q = value;
         CSR_MAX_FACTOR: max_factor_q = value;
         CSR_SPLIT_GAIN: split_q = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every expected response is back, plus the pipeline depth.
   task automatic drain_pipeline();
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Sends one request transaction, idling first at the phase's rate, and
   // queues its expected update at acceptance.
   task automatic send_weight(logic signed [31:0] s, logic signed [31:0] p,
         logic signed [31:0] d, logic signed [31:0] w, logic [6:0] fan,
         bit has_fixed, update_type fixed);
      update_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, fan, w, d, p, s};
      want = quickprop_update(s, p, d, w, fan);
      if (has_fixed) begin
         // Rows typed in by hand must agree with the predictor too.
         if (want !== fixed) begin
            $error("directed row: expected step %0d, predicted %0d", fixed.step, want.step);
            error_count++;
         end
         want = fixed;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_updates.push_back(want);
   endtask

   task automatic add_row(logic signed [31:0] s, logic signed [31:0] p,
         logic signed [31:0] d, logic signed [31:0] w, logic [6:0] fan,
         bit has_fixed, logic signed [31:0] st, logic signed [31:0] wo,
         logic g, logic sat);
      weight_row_type row;
      row.slope = s;
      row.prev_slope = p;
      row.last_step = d;
      row.weight = w;
      row.fan_in = fan;
      row.has_fixed = has_fixed;
      row.fixed = '{st, wo, g, sat};
      directed_rows.push_back(row);
   endtask

   // Random data words: mostly moderate values, sometimes extremes.
   function automatic logic [31:0] random_word();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'd0;
         default: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
      endcase
   endfunction

   task automatic random_registers();
      case ($urandom_range(3))
         0: write_reg(CSR_EPSILON, 20'hFFFFF);
         1: write_reg(CSR_EPSILON, 20'd0);
         default: write_reg(CSR_EPSILON, 20'($urandom()));
      endcase
      write_reg(CSR_MOMENTUM, ($urandom_range(3) == 0) ? 20'h1FFFF : 20'($urandom_range(65536)));
      write_reg(CSR_THRESHOLD, ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom_range(1 << 18)));
      write_reg(CSR_MAX_FACTOR, ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom()));
      write_reg(CSR_SPLIT_GAIN, 20'($urandom_range(1)));
   endtask

   initial begin
      logic signed [31:0] s, p, d, w;
      logic [6:0] fan;
      update_type none;
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      none = '0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_EPSILON;
      csr_wdata <= '0;
      epsilon_q = 20'd36045;
      momentum_q = 17'd58982;
      threshold_q = 20'd0;
      max_factor_q = 20'd114688;
      split_q = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, reset registers. All zero inputs give a zero
      // gradient step; an equal negative slope pair under a positive step
      // skips the growth cap, hits the zero divisor and saturates low.
      add_row(0, 0, 0, 0, 1, 1, 0, 0, 1'b1, 1'b0);
      add_row(-32'sh10000, -32'sh10000, 32'sh10000, 0, 1, 1,
              32'sh80000000, 32'sh80000000, 1'b0, 1'b1);
      add_row(0, 0, 32'sh10000, 0, 1, 1, 0, 0, 1'b0, 1'b1);
      add_row(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 7'd64, 0,
              0, 0, 0, 0);
      add_row(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 7'd0, 0,
              0, 0, 0, 0);
      add_row(32'sh8000, 32'sh4000, 32'sh10000, 32'sh20000, 7'd127, 0, 0, 0, 0, 0);
      add_row(-32'sh8000, -32'sh4000, -32'sh10000, 0, 7'd65, 0, 0, 0, 0, 0);
      add_row(32'sh20000, 32'sh10000, -32'sh8000, 32'sh100, 7'd3, 0, 0, 0, 0, 0);
      add_row(32'sh10000, 32'sh30000, 32'sh10000, 0, 7'd2, 0, 0, 0, 0, 0);
      add_row(-32'sh12345, -32'sh12340, 32'sh7FFFFFFF, 0, 7'd5, 0, 0, 0, 0, 0);
      add_row(32'sh7FFFFFFF, 32'sh7FFFFFFE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 7'd1, 0,
              0, 0, 0, 0);
      add_row(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 7'h55, 0,
              0, 0, 0, 0);
      add_row(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 7'h2A, 0,
              0, 0, 0, 0);
      foreach (directed_rows[i])
         send_weight(directed_rows[i].slope, directed_rows[i].prev_slope,
                     directed_rows[i].last_step, directed_rows[i].weight,
                     directed_rows[i].fan_in, directed_rows[i].has_fixed,
                     directed_rows[i].fixed);
      req_tvalid <= 1'b0;
      drain_pipeline();

      // Extreme register settings with a threshold that splits the modes.
      write_reg(CSR_EPSILON, 20'hFFFFF);
      write_reg(CSR_MOMENTUM, 20'h1FFFF);
      write_reg(CSR_THRESHOLD, 20'h8000);
      write_reg(CSR_MAX_FACTOR, 20'hFFFFF);
      write_reg(CSR_SPLIT_GAIN, 20'd0);
      for (int i = 0; i < 8; i++)
         send_weight(random_word(), random_word(), random_word(), random_word(),
                     7'($urandom()), 0, none);
      req_tvalid <= 1'b0;
      drain_pipeline();

      // Random part in idling phases; registers change before every block.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 35) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 76 : 35) : 0;
         for (int blk = 0; blk < 3; blk++) begin
            random_registers();
            for (int i = 0; i < NUM_RANDOM / 12; i++) begin
               s = random_word();
               // Prev slope often near the slope to exercise the quadratic path.
               p = ($urandom_range(3) == 0) ? s + $signed(32'($urandom_range(8))) - 4
                                            : random_word();
               d = random_word();
               w = random_word();
               fan = ($urandom_range(7) == 0) ? 7'($urandom()) : 7'($urandom_range(64, 1));
               send_weight(s, p, d, w, fan, 0, none);
               if (i == 20 && blk == 0) begin
                  // Hold off until every outstanding result is back.
                  req_tvalid <= 1'b0;
                  while (pending_updates.size() != 0) @(posedge clock);
               end
            end
            req_tvalid <= 1'b0;
            drain_pipeline();
         end
      end

      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/qwu_pkg.sv
design/qwu_div.sv
design/quickprop_weight_update_unit.sv
bench/quickprop_weight_update_unit_tb.sv
